// ----- sv/bvd_pkg.sv -----
// ---------------------------------------------------------------------------
// bvd_pkg
// Shared widths, constants and transaction types of the brush vertex
// displacement pipeline.
// ---------------------------------------------------------------------------
package bvd_pkg;

   // coordinate format
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   localparam int CW   = COORD_WIDTH;
   localparam int FB   = FRAC_BITS;
   // floor square root of the squared length needs one bit more than a coordinate
   localparam int RW   = CW + 1;
   // sum of three squared (CW+1)-bit magnitudes
   localparam int SUMW = 2 * CW + 2;

   // inflate dead zone around the centre, squared, in coordinate LSBs
   localparam int EPS_LSB = (1 << FB) / 10000;
   localparam logic [SUMW-1:0] EPS_SQ = SUMW'(EPS_LSB * EPS_LSB);

   // brush kinds
   localparam logic MODE_GRAB    = 1'b0;
   localparam logic MODE_INFLATE = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic signed [CW-1:0] pos_x;
      logic signed [CW-1:0] pos_y;
      logic signed [CW-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] new_x;
      logic signed [CW-1:0] new_y;
      logic signed [CW-1:0] new_z;
      logic                 moved;
   } rsp_type;

   // per-item context carried down the pipeline next to the arithmetic
   typedef struct packed {
      logic                valid;
      logic                mode;
      logic [2:0][CW-1:0]  pos;
      logic [2:0]          dneg;
      logic [2:0][CW:0]    dmag;
      logic                in_rad;
      logic                big;
      logic [RW-1:0]       dlen;
      logic [2:0][CW-1:0]  grab;
   } trk_type;

endpackage

// ----- sv/sculpt_brush_vertex_displace.sv -----
// ---------------------------------------------------------------------------
// sculpt_brush_vertex_displace
// Displaces one vertex per transaction by a grab or inflate brush with a
// linear falloff around a configured centre; results saturate.
//
//   channel   ports                          direction   payload
//   request   req_valid/req_ready/req_data   in          bvd_pkg::req_type
//   response  rsp_valid/rsp_ready/rsp_data   out         bvd_pkg::rsp_type
//   config    csr_wr_en/csr_index/csr_wdata  in          register write
//
// One transaction enters per cycle while the output buffer is not full;
// Q16.16 operands pass through the bit-per-stage square root, falloff
// divider and inflate dividers in series.
// Synchronous reset clears the valid bits, the output buffer and the
// brush registers. A two-entry output buffer takes results while the
// consumer stalls; the pipeline holds only when both entries are full.
// ---------------------------------------------------------------------------
module sculpt_brush_vertex_displace (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bvd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bvd_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import bvd_pkg::*;

   // register indexes
   localparam logic [2:0] REG_CENTER_X = 3'd0;
   localparam logic [2:0] REG_CENTER_Y = 3'd1;
   localparam logic [2:0] REG_CENTER_Z = 3'd2;
   localparam logic [2:0] REG_OFFSET_X = 3'd3;
   localparam logic [2:0] REG_OFFSET_Y = 3'd4;
   localparam logic [2:0] REG_OFFSET_Z = 3'd5;
   localparam logic [2:0] REG_RADIUS   = 3'd6;
   localparam logic [2:0] REG_STRENGTH = 3'd7;

   // stage positions along the context line
   localparam int KFLAG = 3;
   localparam int KD    = KFLAG + RW;
   localparam int KA    = KD + 1;
   localparam int KF    = KA + FB + 1;
   localparam int KM    = KF + 1;
   localparam int KP    = KM + 1;
   localparam int KQ    = KP + CW;
   localparam int NST   = KQ + 1;

   // brush registers
   logic [2:0][CW-1:0] center_ff;
   logic [2:0][CW-1:0] offset_ff;
   logic [CW-2:0]      radius_ff;
   logic [CW-1:0]      strength_ff;

   // pipeline
   logic                 en;
   trk_type [NST-1:0]    trk_ff;
   trk_type [NST-1:0]    trk_in;
   logic [2:0][CW:0]     dmag_c;
   logic [2:0]           dneg_c;
   logic [2:0][SUMW-1:0] sq_ff;
   logic [2:0][SUMW-1:0] sq_in;
   logic [SUMW-1:0]      rad2_ff;
   logic [SUMW-1:0]      sum3_ff;
   logic [SUMW-1:0]      sum4_ff;
   logic [RW-1:0]        root_q;
   logic [CW-2:0]        a_ff;
   logic [FB:0]          f_q;
   logic [CW-1:0]        m_ff;
   logic [CW-1:0]        m_in;
   logic [2:0][CW-1:0]   grab_c;
   logic [2:0][2*CW-1:0] prod_ff;
   logic [2:0][2*CW-1:0] prod_in;
   logic [2:0][CW-1:0]   t_q;

   // output buffer
   rsp_type res_c;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_valid_ff;
   logic    skid_valid_ff;
   logic    pop;
   logic    push;

   // write brush registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff   <= '0;
         offset_ff   <= '0;
         radius_ff   <= '0;
         strength_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_CENTER_X: center_ff[0] <= csr_wdata[CW-1:0];
            REG_CENTER_Y: center_ff[1] <= csr_wdata[CW-1:0];
            REG_CENTER_Z: center_ff[2] <= csr_wdata[CW-1:0];
            REG_OFFSET_X: offset_ff[0] <= csr_wdata[CW-1:0];
            REG_OFFSET_Y: offset_ff[1] <= csr_wdata[CW-1:0];
            REG_OFFSET_Z: offset_ff[2] <= csr_wdata[CW-1:0];
            REG_RADIUS:   radius_ff    <= csr_wdata[CW-2:0];
            REG_STRENGTH: strength_ff  <= csr_wdata[CW-1:0];
            default:      ;
         endcase
      end
   end

   // advance the whole pipeline unless the output buffer is full
   assign en        = !skid_valid_ff;
   assign req_ready = en;

   // difference to the centre, as sign and magnitude
   always_comb begin
      logic [2:0][CW-1:0] pos;
      logic [CW:0]        d;
      pos = {req_data.pos_z, req_data.pos_y, req_data.pos_x};
      for (int i = 0; i < 3; i++) begin
         d         = {pos[i][CW-1], pos[i]} - {center_ff[i][CW-1], center_ff[i]};
         dneg_c[i] = d[CW];
         dmag_c[i] = d[CW] ? (CW+1)'(-d) : d;
      end
   end

   // grab terms, straight from the falloff
   always_comb begin
      logic [CW+FB:0] gp;
      logic [CW+FB:0] mp;
      logic [CW-1:0]  om;
      logic [CW-1:0]  sm;
      for (int i = 0; i < 3; i++) begin
         om        = offset_ff[i][CW-1] ? CW'(-offset_ff[i]) : offset_ff[i];
         gp        = om * f_q;
         grab_c[i] = gp[FB +: CW];
      end
      sm   = strength_ff[CW-1] ? CW'(-strength_ff) : strength_ff;
      mp   = sm * f_q;
      m_in = mp[FB +: CW];
   end

   // squares and inflate products
   always_comb begin
      logic [2*CW:0] pp;
      for (int i = 0; i < 3; i++) begin
         sq_in[i]   = trk_ff[0].dmag[i] * trk_ff[0].dmag[i];
         pp         = trk_ff[KM].dmag[i] * m_ff;
         prod_in[i] = pp[2*CW-1:0];
      end
   end

   // context line: load at entry, fill in fields as they become known
   always_comb begin
      for (int k = 0; k < NST; k++) begin
         if (k == 0) begin
            trk_in[k]       = '0;
            trk_in[k].valid = req_valid;
            trk_in[k].mode  = req_data.mode;
            trk_in[k].pos   = {req_data.pos_z, req_data.pos_y, req_data.pos_x};
            trk_in[k].dneg  = dneg_c;
            trk_in[k].dmag  = dmag_c;
         end else begin
            trk_in[k] = trk_ff[k-1];
            if (k == KFLAG) begin
               trk_in[k].in_rad = rad2_ff > sum3_ff;
               trk_in[k].big    = sum3_ff > EPS_SQ;
            end
            if (k == KA) begin
               trk_in[k].dlen = root_q;
            end
            if (k == KM) begin
               trk_in[k].grab = grab_c;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) begin
            trk_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         trk_ff <= trk_in;
      end
   end

   // arithmetic registers beside the context line
   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff   <= sq_in;
         rad2_ff <= SUMW'(radius_ff * radius_ff);
         sum3_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         sum4_ff <= sum3_ff;
         a_ff    <= (CW-1)'(RW'(radius_ff) - root_q);
         m_ff    <= m_in;
         prod_ff <= prod_in;
      end
   end

   bvd_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .sum   (sum4_ff),
      .root  (root_q)
   );

   bvd_fdiv u_fdiv (
      .clock (clock),
      .en    (en),
      .a     (a_ff),
      .rad   (radius_ff),
      .f     (f_q)
   );

   for (genvar i = 0; i < 3; i++) begin : g_qdiv
      bvd_qdiv u_qdiv (
         .clock (clock),
         .en    (en),
         .num   (prod_ff[i]),
         .den   (trk_ff[KP].dlen),
         .q     (t_q[i])
      );
   end

   // apply the displacement and saturate
   always_comb begin
      logic [2:0][CW-1:0] nv;
      logic [CW-1:0]      p;
      logic [CW-1:0]      term;
      logic               neg;
      logic               apply;
      logic [CW+1:0]      sw;
      apply = trk_ff[KQ].in_rad &&
              (trk_ff[KQ].mode == MODE_GRAB || trk_ff[KQ].big);
      for (int i = 0; i < 3; i++) begin
         p = trk_ff[KQ].pos[i];
         if (trk_ff[KQ].mode == MODE_GRAB) begin
            neg  = offset_ff[i][CW-1];
            term = trk_ff[KQ].grab[i];
         end else begin
            neg  = trk_ff[KQ].dneg[i] ^ strength_ff[CW-1];
            term = t_q[i];
         end
         sw = neg ? ({{2{p[CW-1]}}, p} - {2'b00, term})
                  : ({{2{p[CW-1]}}, p} + {2'b00, term});
         if (!apply) begin
            nv[i] = p;
         end else if (sw[CW+1:CW-1] == '0 || sw[CW+1:CW-1] == '1) begin
            nv[i] = sw[CW-1:0];
         end else if (sw[CW+1]) begin
            nv[i] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            nv[i] = {1'b0, {(CW-1){1'b1}}};
         end
      end
      res_c.new_x = nv[0];
      res_c.new_y = nv[1];
      res_c.new_z = nv[2];
      res_c.moved = apply;
   end

   // output register with skid entry
   assign pop  = out_valid_ff && rsp_ready;
   assign push = en && trk_ff[KQ].valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff <= res_c;
         end else begin
            skid_ff <= res_c;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- sv/bvd_sqrt.sv -----
// ---------------------------------------------------------------------------
// bvd_sqrt
// Pipelined floor square root, one result bit per stage, RW stages.
// ---------------------------------------------------------------------------
module bvd_sqrt (
   input  logic                      clock,
   input  logic                      en,
   input  logic [bvd_pkg::SUMW-1:0]  sum,
   output logic [bvd_pkg::RW-1:0]    root
);
   import bvd_pkg::*;

   logic [RW-1:0][SUMW-1:0] rem_ff;
   logic [RW-1:0][SUMW-1:0] rem_in;
   logic [RW-1:0][RW-1:0]   root_ff;
   logic [RW-1:0][RW-1:0]   root_in;

   // test one root bit per stage against the running remainder
   always_comb begin
      logic [SUMW-1:0] rem_p;
      logic [SUMW-1:0] trial;
      logic [RW-1:0]   root_p;
      for (int k = 0; k < RW; k++) begin
         if (k == 0) begin
            rem_p  = sum;
            root_p = '0;
         end else begin
            rem_p  = rem_ff[k-1];
            root_p = root_ff[k-1];
         end
         trial = (SUMW'(root_p) << (RW - k)) + (SUMW'(1) << (2 * (RW - 1 - k)));
         if (rem_p >= trial) begin
            rem_in[k]  = rem_p - trial;
            root_in[k] = root_p | (RW'(1) << (RW - 1 - k));
         end else begin
            rem_in[k]  = rem_p;
            root_in[k] = root_p;
         end
      end
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff[RW-1];

endmodule

// ----- sv/bvd_fdiv.sv -----
// ---------------------------------------------------------------------------
// bvd_fdiv
// Pipelined falloff divider: (a << FB) / rad, a no larger than rad,
// one quotient bit per stage, FB+1 stages.
// ---------------------------------------------------------------------------
module bvd_fdiv (
   input  logic                    clock,
   input  logic                    en,
   input  logic [bvd_pkg::CW-2:0]  a,
   input  logic [bvd_pkg::CW-2:0]  rad,
   output logic [bvd_pkg::FB:0]    f
);
   import bvd_pkg::*;

   localparam int NS = FB + 1;

   logic [NS-1:0][CW-2:0] rem_ff;
   logic [NS-1:0][CW-2:0] rem_in;
   logic [NS-1:0][FB:0]   q_ff;
   logic [NS-1:0][FB:0]   q_in;

   // restoring division step per stage
   always_comb begin
      logic [CW-1:0] r;
      logic [FB:0]   q_p;
      logic          ge;
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            r   = {1'b0, a};
            q_p = '0;
         end else begin
            r   = {rem_ff[k-1], 1'b0};
            q_p = q_ff[k-1];
         end
         ge        = (r >= {1'b0, rad});
         rem_in[k] = ge ? (CW-1)'(r - {1'b0, rad}) : (CW-1)'(r);
         q_in[k]   = {q_p[FB-1:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign f = q_ff[NS-1];

endmodule

// ----- sv/bvd_qdiv.sv -----
// ---------------------------------------------------------------------------
// bvd_qdiv
// Pipelined unsigned divider for the inflate term: a 2*CW-bit numerator by
// an RW-bit divisor, quotient below 2^CW, one quotient bit per stage.
// ---------------------------------------------------------------------------
module bvd_qdiv (
   input  logic                      clock,
   input  logic                      en,
   input  logic [2*bvd_pkg::CW-1:0]  num,
   input  logic [bvd_pkg::RW-1:0]    den,
   output logic [bvd_pkg::CW-1:0]    q
);
   import bvd_pkg::*;

   logic [CW-1:0][RW-1:0] rem_ff;
   logic [CW-1:0][RW-1:0] rem_in;
   logic [CW-1:0][CW-1:0] lo_ff;
   logic [CW-1:0][CW-1:0] lo_in;
   logic [CW-1:0][RW-1:0] den_ff;
   logic [CW-1:0][RW-1:0] den_in;
   logic [CW-1:0][CW-1:0] q_ff;
   logic [CW-1:0][CW-1:0] q_in;

   // bring down one numerator bit, compare and subtract
   always_comb begin
      logic [RW-1:0] rem_p;
      logic [CW-1:0] lo_p;
      logic [RW-1:0] den_p;
      logic [CW-1:0] q_p;
      logic [RW:0]   r;
      logic          ge;
      for (int k = 0; k < CW; k++) begin
         if (k == 0) begin
            rem_p = RW'(num[2*CW-1:CW]);
            lo_p  = num[CW-1:0];
            den_p = den;
            q_p   = '0;
         end else begin
            rem_p = rem_ff[k-1];
            lo_p  = lo_ff[k-1];
            den_p = den_ff[k-1];
            q_p   = q_ff[k-1];
         end
         r         = {rem_p, lo_p[CW-1]};
         ge        = (r >= {1'b0, den_p});
         rem_in[k] = ge ? RW'(r - {1'b0, den_p}) : RW'(r);
         lo_in[k]  = lo_p << 1;
         den_in[k] = den_p;
         q_in[k]   = {q_p[CW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         lo_ff  <= lo_in;
         den_ff <= den_in;
         q_ff   <= q_in;
      end
   end

   assign q = q_ff[CW-1];

endmodule
